>>> src/bam_pkg.sv
// ---------------------------------------------------------------------------
// Bipartite matcher package
// Shared constants and action codes for the augmenting-path matcher.
// ---------------------------------------------------------------------------
package bam_pkg;
  localparam int MAX_LEFT   = 16;
  localparam int MAX_RIGHT  = 16;
  localparam int MAX_DEGREE = 16;
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_SOLVE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [4:0] CFG_LEFT  = 5'd0;
  localparam logic [4:0] CFG_RIGHT = 5'd1;
endpackage

>>> src/bipartite_augmenting_matcher.sv
// ---------------------------------------------------------------------------
// Bipartite augmenting-path matcher
// Kuhn matching over stored edge lists with an explicit depth-first stack.
// ---------------------------------------------------------------------------
// Add edge and clear each pass through their own state (S_ADD, S_CLEAR), which
// registers their single result. An unknown action is taken and yields no result.
// Solve: release stale pairs, then visit each unmatched left vertex, scanning edge
// list entries (read, then check), popping finished levels and rematching levels,
// then count the matched left vertices in use and send one report line for each in use.
// busy falls in the cycle that shows the last result; the receiver cannot
// stall. Reset clears lists and matching and sets both counts to the maximum.
module bipartite_augmenting_matcher #(
  parameter int MAX_LEFT   = bam_pkg::MAX_LEFT,
  parameter int MAX_RIGHT  = bam_pkg::MAX_RIGHT,
  parameter int MAX_DEGREE = bam_pkg::MAX_DEGREE
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] action,
  input  logic [3:0] left_vertex,
  input  logic [3:0] right_vertex,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_index,
  input  logic [4:0] cfg_data,
  output logic       done,
  output logic       status,
  output logic [3:0] left_index,
  output logic       matched,
  output logic [3:0] partner,
  output logic [4:0] match_count,
  output logic       last
);
  localparam int LW = (MAX_LEFT > 1) ? $clog2(MAX_LEFT) : 1;
  localparam int RW = (MAX_RIGHT > 1) ? $clog2(MAX_RIGHT) : 1;
  localparam int DW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int LCW = $clog2(MAX_LEFT + 1);
  localparam int RCW = $clog2(MAX_RIGHT + 1);
  localparam int DCW = $clog2(MAX_DEGREE + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_CLEAR, S_FIX, S_NEXT, S_FREE_RD, S_FREE_CHK,
    S_DFS_RD, S_DFS_CHK, S_AUG_RD, S_AUG_WR, S_COUNT, S_REPORT
  } state_t;

  state_t state;

  // Edge list memory, one row per left vertex.
  logic [RW-1:0] edge_mem [MAX_LEFT*MAX_DEGREE];
  logic [RW-1:0] edge_rd;
  logic [LW+DW-1:0] rd_addr;

  logic [DCW-1:0] list_len [MAX_LEFT];
  logic           lp_valid [MAX_LEFT];
  logic [RW-1:0]  lp_val   [MAX_LEFT];
  logic           rp_valid [MAX_RIGHT];
  logic [LW-1:0]  rp_val   [MAX_RIGHT];
  logic [MAX_LEFT-1:0] visited;
  logic [LW-1:0]  stk_node [MAX_LEFT];
  logic [DCW-1:0] stk_pos  [MAX_LEFT];

  logic [4:0] left_cfg, right_cfg;
  logic [3:0] in_u, in_r;
  logic [LW-1:0] root, cur;   // cur: vertex being scanned by the free-partner search
  logic [DCW-1:0] k;          // free-partner scan position
  logic [LCW-1:0] depth;
  logic [LCW-1:0] idx;
  logic [LCW-1:0] cnt;
  logic           free_from_dfs;

  // Clamped counts.
  logic [LCW-1:0] lc;
  logic [RCW-1:0] rc;
  always_comb begin
    if (left_cfg == 5'd0) lc = LCW'(1);
    else if (32'(left_cfg) > MAX_LEFT) lc = LCW'(MAX_LEFT);
    else lc = LCW'(left_cfg);
    if (right_cfg == 5'd0) rc = RCW'(1);
    else if (32'(right_cfg) > MAX_RIGHT) rc = RCW'(MAX_RIGHT);
    else rc = RCW'(right_cfg);
  end

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  logic [LW-1:0] top_node;
  logic [DCW-1:0] top_pos;
  logic [LW-1:0] dtop;
  assign dtop = LW'(depth - LCW'(1));
  assign top_node = stk_node[dtop];
  assign top_pos  = stk_pos[dtop];

  // Read address for the shared memory port.
  always_comb begin
    rd_addr = {top_node, DW'(top_pos)};
    if (state == S_FREE_RD) rd_addr = {cur, DW'(k)};
  end

  always_ff @(posedge clk) begin
    if (state == S_ADD && 32'(in_u) < 32'(lc) && 32'(in_r) < 32'(rc) &&
        list_len[LW'(in_u)] < DCW'(MAX_DEGREE))
      edge_mem[{LW'(in_u), DW'(list_len[LW'(in_u)])}] <= RW'(in_r);
    edge_rd <= edge_mem[rd_addr];
  end

  logic r_ok;
  logic [LW-1:0] x;
  logic x_ok;
  assign r_ok = 32'(edge_rd) < 32'(rc);
  assign x    = rp_val[edge_rd];
  assign x_ok = r_ok && rp_valid[edge_rd] && 32'(x) < 32'(lc) && !visited[x];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      left_cfg <= 5'd16;
      right_cfg <= 5'd16;
      visited <= '0;
      depth <= '0;
      for (int i = 0; i < MAX_LEFT; i++) begin
        list_len[i] <= '0;
        lp_valid[i] <= 1'b0;
      end
      for (int i = 0; i < MAX_RIGHT; i++) rp_valid[i] <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            if (cfg_index == bam_pkg::CFG_LEFT) left_cfg <= cfg_data;
            else if (cfg_index == bam_pkg::CFG_RIGHT) right_cfg <= cfg_data;
          end
          if (start) begin
            in_u <= left_vertex; in_r <= right_vertex;
            case (action)
              bam_pkg::ACT_ADD:   state <= S_ADD;
              bam_pkg::ACT_SOLVE: state <= S_FIX;
              bam_pkg::ACT_CLEAR: state <= S_CLEAR;
              default:            state <= S_IDLE;
            endcase
          end
        end
        S_ADD: begin
          left_index <= '0; matched <= 1'b0; partner <= '0; match_count <= '0;
          last <= 1'b1; done <= 1'b1;
          if (32'(in_u) < 32'(lc) && 32'(in_r) < 32'(rc) &&
              list_len[LW'(in_u)] < DCW'(MAX_DEGREE)) begin
            list_len[LW'(in_u)] <= list_len[LW'(in_u)] + DCW'(1);
            status <= 1'b0;
          end else begin
            status <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_CLEAR: begin
          {status, left_index, matched, partner, match_count} <= '0;
          last <= 1'b1; done <= 1'b1;
          for (int i = 0; i < MAX_LEFT; i++) begin
            list_len[i] <= '0; lp_valid[i] <= 1'b0;
          end
          for (int i = 0; i < MAX_RIGHT; i++) rp_valid[i] <= 1'b0;
          state <= S_IDLE;
        end
        S_FIX: begin
          // Release pairings that involve vertices out of use or disagree.
          for (int i = 0; i < MAX_LEFT; i++)
            if (lp_valid[i] && (i >= 32'(lc) || 32'(lp_val[i]) >= 32'(rc))) begin
              lp_valid[i] <= 1'b0;
            end
          for (int i = 0; i < MAX_RIGHT; i++)
            if (rp_valid[i]) begin
              if (i >= 32'(rc) || 32'(rp_val[i]) >= 32'(lc) ||
                  !lp_valid[rp_val[i]] || 32'(lp_val[rp_val[i]]) != i ||
                  32'(rp_val[i]) >= 32'(lc) || 32'(lp_val[rp_val[i]]) >= 32'(rc))
                rp_valid[i] <= 1'b0;
            end
          idx <= '0;
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (idx >= lc) begin
            idx <= '0; cnt <= '0; state <= S_COUNT;
          end else if (lp_valid[LW'(idx)]) begin
            idx <= idx + LCW'(1);
          end else begin
            root <= LW'(idx);
            // Fresh visited marks with only the root set.
            visited <= {{(MAX_LEFT-1){1'b0}}, 1'b1} << LW'(idx);
            cur <= LW'(idx); k <= '0; free_from_dfs <= 1'b0;
            depth <= '0;
            state <= S_FREE_RD;
          end
        end
        S_FREE_RD: begin
          if (k >= list_len[cur]) begin
            if (!free_from_dfs) begin
              stk_node[0] <= root; stk_pos[0] <= '0; depth <= LCW'(1);
            end else begin
              stk_node[LW'(depth)] <= cur; stk_pos[LW'(depth)] <= '0;
              depth <= depth + LCW'(1);
            end
            state <= S_DFS_RD;
          end else state <= S_FREE_CHK;
        end
        S_FREE_CHK: begin
          if (r_ok && !rp_valid[edge_rd]) begin
            lp_valid[cur] <= 1'b1; lp_val[cur] <= edge_rd;
            rp_valid[edge_rd] <= 1'b1; rp_val[edge_rd] <= cur;
            if (free_from_dfs && depth != '0) state <= S_AUG_RD;
            else begin idx <= idx + LCW'(1); state <= S_NEXT; end
          end else begin
            k <= k + DCW'(1); state <= S_FREE_RD;
          end
        end
        S_DFS_RD: begin
          if (depth == '0) begin
            idx <= idx + LCW'(1); state <= S_NEXT;
          end else if (top_pos >= list_len[top_node]) begin
            // List fully scanned: pop and move the parent to its next entry.
            depth <= depth - LCW'(1);
            if (depth > LCW'(1)) stk_pos[LW'(depth - LCW'(2))] <=
                stk_pos[LW'(depth - LCW'(2))] + DCW'(1);
          end else state <= S_DFS_CHK;
        end
        S_DFS_CHK: begin
          if (!x_ok || 32'(depth) >= MAX_LEFT) begin
            stk_pos[dtop] <= top_pos + DCW'(1);
            state <= S_DFS_RD;
          end else begin
            visited[x] <= 1'b1;
            cur <= x; k <= '0; free_from_dfs <= 1'b1;
            state <= S_FREE_RD;
          end
        end
        S_AUG_RD: begin
          // Read edge at stack top for rematching.
          state <= S_AUG_WR;
        end
        S_AUG_WR: begin
          lp_valid[top_node] <= 1'b1; lp_val[top_node] <= edge_rd;
          rp_valid[edge_rd] <= 1'b1; rp_val[edge_rd] <= top_node;
          depth <= depth - LCW'(1);
          if (depth == LCW'(1)) begin
            idx <= idx + LCW'(1); state <= S_NEXT;
          end else state <= S_AUG_RD;
        end
        S_COUNT: begin
          if (idx >= lc) begin idx <= '0; state <= S_REPORT; end
          else begin
            if (lp_valid[LW'(idx)]) cnt <= cnt + LCW'(1);
            idx <= idx + LCW'(1);
          end
        end
        S_REPORT: begin
          done <= 1'b1;
          status <= 1'b0;
          left_index <= 4'(idx);
          matched <= lp_valid[LW'(idx)];
          partner <= lp_valid[LW'(idx)] ? 4'(lp_val[LW'(idx)]) : 4'd0;
          match_count <= 5'(cnt);
          last <= (idx + LCW'(1) == lc);
          idx <= idx + LCW'(1);
          if (idx + LCW'(1) == lc) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> src/bam_checker.sv
// ---------------------------------------------------------------------------
// Bipartite matcher port checker
// Port-level properties of the matcher, bound to the matcher module.
// ---------------------------------------------------------------------------
module bam_checker (
  input logic clk, rst, busy, cfg_ready, done, last, status, matched,
  input logic [3:0] partner,
  input logic [4:0] match_count
);
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !busy) else $error("config ready while busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> busy) else $error("result stream left block idle");
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    done && last |-> !busy) else $error("busy after last result");
  a_unmatched: assert property (@(posedge clk) disable iff (rst)
    done && !matched |-> partner == 4'd0) else $error("partner without match");
  a_status: assert property (@(posedge clk) disable iff (rst)
    done && status |-> last && match_count == 5'd0) else $error("bad status line");
endmodule

bind bipartite_augmenting_matcher bam_checker u_bam_checker (
  .clk(clk), .rst(rst), .busy(busy), .cfg_ready(cfg_ready),
  .done(done), .last(last), .status(status), .matched(matched),
  .partner(partner), .match_count(match_count)
);
